FILE: rtl/windowed_moving_average_unit_assert.svh
// Assertion macros shared by the windowed moving average unit.
`ifndef WINDOWED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Condition holds at every edge outside reset.
`define WMA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wma_pkg.sv
package wma_pkg;

    localparam int RING_DEPTH    = 1024;
    localparam int SAMPLE_BITS   = 32;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int WIN_BITS      = 11;
    localparam int PREFIX_BITS   = 48;
    localparam int FRAC_BITS     = 8;
    localparam int AVG_BITS      = 40;
    localparam int DIVIDEND_BITS = PREFIX_BITS + FRAC_BITS;

    localparam int SLOT_BITS     = $clog2(RING_DEPTH);
    localparam int COUNT_BITS    = $clog2(RING_DEPTH + 1);
    localparam int OFS_BITS      = SLOT_BITS + 2;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);

    localparam logic [WIN_BITS-1:0]  WIN_RESET = WIN_BITS'(1024);
    localparam logic [STEP_BITS-1:0] ADD_LAST  = STEP_BITS'(PREFIX_BITS - 1);
    localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(DIVIDEND_BITS - 1);

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_WIDTH) ?
        {SAMPLE_WIDTH{1'b1}} : SAMPLE_WIDTH'((64'd1 << SAMPLE_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_ADD,
        ST_DLOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    // load: capture operands, step: process one bit
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

endpackage

FILE: rtl/wma_ram.sv
module wma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/wma_serial_add.sv
module wma_serial_add import wma_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ser_ctl               i_ctl,
    input  logic [PREFIX_BITS-1:0] i_addend,
    input  logic [PREFIX_BITS-1:0] i_subtrahend,
    output logic [PREFIX_BITS-1:0] o_prefix,
    output logic [PREFIX_BITS-1:0] o_diff
);

    // Running prefix rotates LSB first; after PREFIX_BITS steps it is back in place.
    logic [PREFIX_BITS-1:0] r_prefix;
    logic [PREFIX_BITS-1:0] r_addend;
    logic [PREFIX_BITS-1:0] r_sub;
    logic [PREFIX_BITS-1:0] r_diff;
    logic                   r_carry;
    logic                   r_borrow_n;

    logic sum_bit;
    logic sum_carry;
    logic sub_b;
    logic diff_bit;
    logic diff_carry;

    always_comb begin
        sum_bit    = r_prefix[0] ^ r_addend[0] ^ r_carry;
        sum_carry  = (r_prefix[0] & r_addend[0]) | (r_carry & (r_prefix[0] ^ r_addend[0]));
        // new prefix minus ring entry as a + ~b + 1
        sub_b      = ~r_sub[0];
        diff_bit   = sum_bit ^ sub_b ^ r_borrow_n;
        diff_carry = (sum_bit & sub_b) | (r_borrow_n & (sum_bit ^ sub_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
        end else if (i_ctl.step) begin
            r_prefix <= {sum_bit, r_prefix[PREFIX_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_addend   <= i_addend;
            r_sub      <= i_subtrahend;
            r_carry    <= 1'b0;
            r_borrow_n <= 1'b1;
        end else if (i_ctl.step) begin
            r_addend   <= {1'b0, r_addend[PREFIX_BITS-1:1]};
            r_sub      <= {1'b0, r_sub[PREFIX_BITS-1:1]};
            r_diff     <= {diff_bit, r_diff[PREFIX_BITS-1:1]};
            r_carry    <= sum_carry;
            r_borrow_n <= diff_carry;
        end
    end

    assign o_prefix = r_prefix;
    assign o_diff   = r_diff;

endmodule

FILE: rtl/wma_serial_div.sv
module wma_serial_div import wma_pkg::*; (
    input  logic                     i_clk,
    input  t_ser_ctl                 i_ctl,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [WIN_BITS-1:0]      i_divisor,
    output logic [AVG_BITS-1:0]      o_quotient
);

    // Restoring division, one quotient bit per step, MSB first.
    logic [DIVIDEND_BITS-1:0] r_dvd;
    logic [WIN_BITS-1:0]      r_rem;
    logic [AVG_BITS-1:0]      r_quo;

    logic [WIN_BITS+1:0] trial;
    logic                fits;

    always_comb begin
        trial = {1'b0, r_rem, r_dvd[DIVIDEND_BITS-1]} - {2'b00, i_divisor};
        fits  = ~trial[WIN_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[DIVIDEND_BITS-2:0], 1'b0};
            r_rem <= fits ? trial[WIN_BITS-1:0] : {r_rem[WIN_BITS-2:0], r_dvd[DIVIDEND_BITS-1]};
            // high quotient bits fall off the top: result is taken modulo 2^AVG_BITS
            r_quo <= {r_quo[AVG_BITS-2:0], fits};
        end
    end

    assign o_quotient = r_quo;

endmodule

FILE: rtl/windowed_moving_average_unit.sv
// Each word runs ST_READ, ST_LOAD, ST_ADD, ST_DLOAD, ST_DIV and ST_DONE before the next is accepted;
// the bit-serial prefix add/subtract (48 steps) and the bit-serial divider (56 steps)
// dominate, plus one ring write and one ring read.
// A new word is accepted while a finished result still waits at the output.
// Reset (synchronous, active low): prefix, slot, count and output valid cleared, window 1024.
// The prefix ring is not cleared; the sample count guards every use of a value read from it.
`include "windowed_moving_average_unit_assert.svh"

module windowed_moving_average_unit import wma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [AVG_BITS-1:0]     o_average_value,
    output logic                    o_average_valid,
    input  logic                    i_cfg_wr_en,
    input  logic [WIN_BITS-1:0]     i_cfg_wr_data
);

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_BITS-1:0]   r_step;
    logic [STEP_BITS-1:0]   n_step;

    logic [WIN_BITS-1:0]    r_win_len;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [COUNT_BITS-1:0]  r_count;
    logic [PREFIX_BITS-1:0] r_sample;
    logic [SLOT_BITS-1:0]   r_old_addr;
    logic [WIN_BITS-1:0]    r_win_eff;
    logic                   r_win_ok;

    logic                   r_out_valid;
    logic [AVG_BITS-1:0]    r_avg;
    logic                   r_avg_ok;

    t_ser_ctl               add_ctl;
    t_ser_ctl               div_ctl;
    logic                   rd_en;
    logic                   out_load;
    logic                   in_acc;

    logic [SLOT_BITS-1:0]   slot_next;
    logic [COUNT_BITS-1:0]  count_next;
    logic [WIN_BITS-1:0]    win_eff;
    logic [OFS_BITS-1:0]    ofs_sum;
    logic [OFS_BITS-1:0]    ofs_wrap;
    logic                   win_ok;

    logic [PREFIX_BITS-1:0] prefix;
    logic [PREFIX_BITS-1:0] diff;
    logic [PREFIX_BITS-1:0] ring_rd;
    logic [AVG_BITS-1:0]    quotient;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        slot_next  = (r_slot == SLOT_BITS'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        count_next = (r_count == COUNT_BITS'(RING_DEPTH)) ? r_count : r_count + 1'b1;
        // a zero window counts as one
        win_eff    = (r_win_len == '0) ? WIN_BITS'(1) : r_win_len;
        win_ok     = (32'(win_eff) <= 32'(RING_DEPTH)) && (32'(count_next) >= 32'(win_eff));
        // oldest prefix: slot_next - window, modulo the ring depth
        ofs_sum    = OFS_BITS'(slot_next) + OFS_BITS'(RING_DEPTH) - OFS_BITS'(win_eff);
        ofs_wrap   = (ofs_sum >= OFS_BITS'(RING_DEPTH)) ? ofs_sum - OFS_BITS'(RING_DEPTH)
                                                        : ofs_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_win_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
        end else if (in_acc) begin
            r_slot  <= slot_next;
            r_count <= count_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample   <= PREFIX_BITS'(i_sample_value & SAMPLE_MASK);
            r_old_addr <= SLOT_BITS'(ofs_wrap);
            r_win_eff  <= win_eff;
            r_win_ok   <= win_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        add_ctl  = '0;
        div_ctl  = '0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                rd_en   = 1'b1;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                add_ctl.load = 1'b1;
                n_step       = ADD_LAST;
                n_state      = ST_ADD;
            end
            ST_ADD: begin
                add_ctl.step = 1'b1;
                n_step       = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                div_ctl.load = 1'b1;
                n_step       = DIV_LAST;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                div_ctl.step = 1'b1;
                n_step       = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    wma_ram #(
        .WIDTH (PREFIX_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_slot),
        .i_wr_data (prefix),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_old_addr),
        .o_rd_data (ring_rd)
    );

    wma_serial_add u_add (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (add_ctl),
        .i_addend     (r_sample),
        .i_subtrahend (ring_rd),
        .o_prefix     (prefix),
        .o_diff       (diff)
    );

    wma_serial_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_dividend ({diff, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_win_eff),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_avg    <= r_win_ok ? quotient : '0;
            r_avg_ok <= r_win_ok;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average_value = r_avg;
    assign o_average_valid = r_avg_ok;

    `WMA_ASSERT_ALWAYS(a_invalid_zero, i_clk, i_rst_n, !(o_valid && !o_average_valid) || (o_average_value == '0), "average nonzero while not valid")
    `WMA_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, 32'(r_count) <= 32'(RING_DEPTH), "sample count beyond ring depth")
    `WMA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "accepted word did not stall input")
    `WMA_ASSERT_NEXT(a_done_output, i_clk, i_rst_n, out_load, o_valid && !o_stall, "result not presented after done")

endmodule

FILE: tb/windowed_moving_average_unit_tb.sv
`timescale 1ns / 1ps

module windowed_moving_average_unit_tb;
    import wma_pkg::*;

    localparam int BLOCK_LATENCY = 108;
    localparam int LONG_HOLD     = 800;

    typedef struct packed {
        logic [AVG_BITS-1:0] value;
        logic                valid;
    } t_avg_word;

    logic                    i_clk;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [SAMPLE_WIDTH-1:0] i_sample_value = '0;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [AVG_BITS-1:0]     o_average_value;
    logic                    o_average_valid;
    logic                    i_cfg_wr_en    = 1'b0;
    logic [WIN_BITS-1:0]     i_cfg_wr_data  = '0;

    windowed_moving_average_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_average_value (o_average_value),
        .o_average_valid (o_average_valid),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // predictor state
    logic [PREFIX_BITS-1:0]  prefix_hist [RING_DEPTH];
    logic [PREFIX_BITS-1:0]  prefix_sum   = '0;
    int unsigned             slot_ptr     = 0;
    int unsigned             sample_count = 0;
    logic [WIN_BITS-1:0]     window_cfg   = WIN_RESET;

    logic [SAMPLE_WIDTH-1:0] sample_queue [$];
    t_avg_word               average_expectations [$];
    t_avg_word               want;

    int unsigned samples_queued = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned full_windows   = 0;
    int unsigned windows_used   = 0;
    int unsigned input_stalls   = 0;
    int unsigned errors         = 0;

    logic        sample_taken = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_mode   = 0;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) prefix_hist[i] = '0;
    end

    task automatic predict_average(input logic [SAMPLE_WIDTH-1:0] smp);
        logic [PREFIX_BITS-1:0]   diff;
        logic [DIVIDEND_BITS-1:0] dividend;
        int unsigned              w;
        int unsigned              oldest;
        t_avg_word                exp_word;
        prefix_hist[slot_ptr] = prefix_sum;
        prefix_sum = prefix_sum + PREFIX_BITS'(smp & SAMPLE_MASK);
        slot_ptr = (slot_ptr + 1) % RING_DEPTH;
        if (sample_count < RING_DEPTH) sample_count++;
        w = (window_cfg == '0) ? 1 : int'(window_cfg);
        exp_word = '0;
        if (w <= RING_DEPTH && sample_count >= w) begin
            oldest = (slot_ptr + RING_DEPTH - w) % RING_DEPTH;
            diff = prefix_sum - prefix_hist[oldest];
            dividend = {diff, {FRAC_BITS{1'b0}}};
            exp_word.value = AVG_BITS'(dividend / DIVIDEND_BITS'(w));
            exp_word.valid = 1'b1;
        end
        average_expectations.insert(average_expectations.size(), exp_word);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            2: return SAMPLE_WIDTH'($urandom_range(0, 255));
            3: return '1 - SAMPLE_WIDTH'($urandom_range(0, 1000));
            4: return SAMPLE_WIDTH'(1) << $urandom_range(0, SAMPLE_WIDTH - 1);
            default: return SAMPLE_WIDTH'($urandom());
        endcase
    endfunction

    task automatic queue_sample(input logic [SAMPLE_WIDTH-1:0] smp);
        sample_queue.insert(sample_queue.size(), smp);
        samples_queued++;
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || average_expectations.size() != 0)
            @(negedge i_clk);
    endtask

    // window register only changes with nothing in flight
    task automatic set_window(input int unsigned w);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= WIN_BITS'(w);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_cfg = WIN_BITS'(w);
        windows_used++;
    endtask

    // input side: acceptance at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid) begin
            if (!o_stall) begin
                predict_average(i_sample_value);
                sample_queue.delete(0);
                samples_sent++;
                sample_taken = 1'b1;
            end else begin
                input_stalls++;
            end
        end
    end

    always @(negedge i_clk) begin
        logic next_valid;
        next_valid = 1'b0;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (i_valid && !sample_taken) begin
            next_valid = 1'b1;
        end else begin
            if (sample_taken && burst_left > 0) begin
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (sample_queue.size() != 0) begin
                next_valid = 1'b1;
                i_sample_value <= sample_queue[0];
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 6);
            end
        end
        sample_taken = 1'b0;
        i_valid <= next_valid;
    end

    // output side: stall pattern plus one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 100 && sample_queue.size() > 8) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (average_expectations.size() == 0) begin
                $error("unexpected average word: average_value %0h average_valid %0b",
                       o_average_value, o_average_valid);
                errors++;
            end else begin
                want = average_expectations[0];
                average_expectations.delete(0);
                if (want.valid) full_windows++;
                if (o_average_value !== want.value) begin
                    $error("average_value: expected %0h, got %0h", want.value, o_average_value);
                    errors++;
                end
                if (o_average_valid !== want.valid) begin
                    $error("average_valid: expected %0b, got %0b", want.valid, o_average_valid);
                    errors++;
                end
            end
        end
    end

    initial begin
        #25_000_000;
        $display("windowed_moving_average_unit_tb failed");
        $finish;
    end

    initial begin
        int unsigned w;
        int unsigned n;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // window still at its reset value: not enough samples, all zero
        queue_sample('0);
        queue_sample('1);
        queue_sample(32'h0000_0001);
        queue_sample(32'h8000_0000);
        queue_sample(32'h5555_5555);
        queue_sample(32'hAAAA_AAAA);

        set_window(1);
        queue_sample('0);
        queue_sample('1);
        queue_sample('1);
        queue_sample(32'h0000_0001);
        queue_sample(32'h7FFF_FFFF);
        queue_sample(32'h8000_0000);

        // zero window behaves as one
        set_window(0);
        queue_sample('1);
        queue_sample('0);
        queue_sample(32'h1234_5678);

        // windows past the ring depth never fill
        set_window(2047);
        queue_sample('1);
        queue_sample(32'h0000_00FF);
        queue_sample('0);
        set_window(RING_DEPTH + 1);
        queue_sample('1);
        queue_sample(32'hDEAD_BEEF);

        set_window(2);
        queue_sample('1);
        queue_sample('1);
        queue_sample('1);
        queue_sample('0);

        while (samples_queued < 600) begin
            case ($urandom_range(0, 11))
                0: w = 0;
                1: w = $urandom_range(RING_DEPTH + 1, 2047);
                2, 3, 4, 5, 6: w = $urandom_range(1, 16);
                default: w = $urandom_range(17, RING_DEPTH);
            endcase
            set_window(w);
            n = $urandom_range(15, 50);
            repeat (n) queue_sample(pick_sample());
        end

        // largest windows that fit the ring depth
        set_window(RING_DEPTH - 1);
        repeat (30) queue_sample(pick_sample());
        set_window(RING_DEPTH);
        repeat (100) queue_sample(pick_sample());

        drain();
        repeat (BLOCK_LATENCY + 20) @(negedge i_clk);

        $display("%0d samples over %0d window settings; %0d averages checked, %0d full windows",
                 samples_sent, windows_used, results_seen, full_windows);
        $display("input held off for %0d cycles while a sample waited", input_stalls);
        if (errors == 0 && average_expectations.size() == 0) begin
            $display("windowed_moving_average_unit_tb passed");
        end else begin
            $display("windowed_moving_average_unit_tb failed");
        end
        $finish;
    end

endmodule
